[design/lobm_pkg.sv]
package lobm_pkg;

    localparam int TOP_PRICE_DEF   = 1023;
    localparam int ORDER_SLOTS_DEF = 4096;

    localparam int ID_IN_W    = 12;
    localparam int PRICE_IN_W = 10;
    localparam int QTY_W      = 24;
    localparam int TOTAL_W    = 36;
    localparam int DONE_W     = 13;
    localparam int STATUS_W   = 2;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 88;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_CANCEL = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_LIVE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DUP      = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHK,
        S_ENT,
        S_CLEV,
        S_MTOP,
        S_MLEV,
        S_MORD,
        S_RS_STEP,
        S_RS_CHK,
        S_REST,
        S_APP,
        S_APP2,
        S_OUT
    } lobm_state_t;

endpackage

[design/lobm_ram.sv]
module lobm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/limit_order_book_matcher_core.sv]
// A cancel takes longer for each price level stepped over when the best price is rescanned.
// An add takes longer for each resting order traded and each level swept or rescanned,
// and longer again when a remainder rests. One transaction in flight; the sequencer sets the rate.
// Result is held in an output register, so the next input is taken while it waits.
// Reset: synchronous, active low; then a clearing pass empties the order entry and level memories
// before input is accepted.
module limit_order_book_matcher_core #(
    parameter int TOP_PRICE   = lobm_pkg::TOP_PRICE_DEF,
    parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // order_ident[11:0], side_sell[12], limit_price[22:13], order_qty[46:23], zero pad
    input  logic [lobm_pkg::S_DATA_W-1:0] s_tdata,
    // kind[0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], filled_qty[25:2], rested_qty[49:26], orders_completed[62:50],
    // best_bid_price[72:63], best_ask_price[82:73], zero pad
    output logic [lobm_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int PW     = $clog2(TOP_PRICE + 1);
    localparam int AW     = $clog2(ORDER_SLOTS);
    localparam int IW     = $clog2(ORDER_SLOTS + 1);
    localparam int LDEPTH = 2 * (TOP_PRICE + 1);
    localparam int LAW    = PW + 1;
    localparam int CLR_N  = (ORDER_SLOTS > LDEPTH) ? ORDER_SLOTS : LDEPTH;
    localparam int CW     = $clog2(CLR_N);
    localparam int QW     = lobm_pkg::QTY_W;
    localparam int TW     = lobm_pkg::TOTAL_W;
    localparam int DW     = lobm_pkg::DONE_W;

    localparam logic [IW-1:0] NIL      = IW'(ORDER_SLOTS);
    localparam logic [PW-1:0] TOPP     = PW'(TOP_PRICE);
    localparam logic [CW-1:0] CLR_LAST = CW'(CLR_N - 1);
    localparam logic [DW-1:0] DONE_MAX = '1;

    typedef struct packed {
        logic          live;
        logic          side;
        logic [PW-1:0] price;
        logic [QW-1:0] qty;
    } ent_t;

    localparam int EW = $bits(ent_t);

    lobm_pkg::lobm_state_t state_reg, state_next;

    logic [CW-1:0]                  clr_reg;
    logic                           kind_reg;
    logic [AW-1:0]                  id_reg;
    logic                           id_bad_reg;
    logic                           sell_reg;
    logic [PW-1:0]                  p_reg;
    logic [QW-1:0]                  q_reg;
    logic [QW-1:0]                  filled_reg;
    logic [QW-1:0]                  rested_reg;
    logic [DW-1:0]                  done_reg;
    logic [lobm_pkg::STATUS_W-1:0]  status_reg;
    logic                           ent_side_reg;
    logic [PW-1:0]                  ent_price_reg;
    logic [QW-1:0]                  ent_qty_reg;
    logic [IW-1:0]                  ent_nx_reg;
    logic [IW-1:0]                  ent_pv_reg;
    logic [PW-1:0]                  lvl_reg;
    logic [IW-1:0]                  cur_reg;
    logic [TW-1:0]                  tot_reg;
    logic                           rs_side_reg;
    logic [PW-1:0]                  best_bid_reg;
    logic [PW-1:0]                  best_ask_reg;
    logic                           m_valid_reg;
    logic [lobm_pkg::M_DATA_W-1:0]  m_data_reg;

    // memory ports
    logic [AW-1:0]  ea;
    logic [LAW-1:0] la;
    logic [LAW-1:0] lwa;
    ent_t           rd_ed;
    logic [EW-1:0]  rd_ed_bits;
    logic [IW-1:0]  rd_enx, rd_epv, rd_lh, rd_lt;
    logic [TW-1:0]  rd_lq;
    logic           ed_we, enx_we, epv_we, lh_we, lt_we, lq_we;
    logic [AW-1:0]  ed_wa, enx_wa, epv_wa;
    ent_t           ed_wd;
    logic [IW-1:0]  enx_wd, epv_wd, lh_wd, lt_wd;
    logic [TW-1:0]  lq_wd;

    assign rd_ed = ent_t'(rd_ed_bits);

    lobm_ram #(.WIDTH(EW), .DEPTH(ORDER_SLOTS)) u_ed (
        .aclk(aclk), .we(ed_we), .waddr(ed_wa), .wdata(ed_wd),
        .raddr(ea), .rdata(rd_ed_bits)
    );
    lobm_ram #(.WIDTH(IW), .DEPTH(ORDER_SLOTS)) u_enx (
        .aclk(aclk), .we(enx_we), .waddr(enx_wa), .wdata(enx_wd),
        .raddr(ea), .rdata(rd_enx)
    );
    lobm_ram #(.WIDTH(IW), .DEPTH(ORDER_SLOTS)) u_epv (
        .aclk(aclk), .we(epv_we), .waddr(epv_wa), .wdata(epv_wd),
        .raddr(ea), .rdata(rd_epv)
    );
    lobm_ram #(.WIDTH(IW), .DEPTH(LDEPTH)) u_lh (
        .aclk(aclk), .we(lh_we), .waddr(lwa), .wdata(lh_wd),
        .raddr(la), .rdata(rd_lh)
    );
    lobm_ram #(.WIDTH(IW), .DEPTH(LDEPTH)) u_lt (
        .aclk(aclk), .we(lt_we), .waddr(lwa), .wdata(lt_wd),
        .raddr(la), .rdata(rd_lt)
    );
    lobm_ram #(.WIDTH(TW), .DEPTH(LDEPTH)) u_lq (
        .aclk(aclk), .we(lq_we), .waddr(lwa), .wdata(lq_wd),
        .raddr(la), .rdata(rd_lq)
    );

    // derived control
    logic          opp;
    logic [PW-1:0] best_opp;
    logic [QW-1:0] t_amt, eq_n, q_n;
    logic [TW-1:0] tot_n;
    logic [IW-1:0] id_ptr;
    logic [IW-1:0] cl_new_head;
    logic          cl_rescan;
    logic          mt_go;
    logic          rs_end;
    logic [PW-1:0] rs_price;
    logic          out_load;
    logic [PW-1:0] s_price_sat;
    logic          s_id_bad;

    assign opp      = ~sell_reg;
    assign best_opp = sell_reg ? best_bid_reg : best_ask_reg;
    assign t_amt    = (q_reg < rd_ed.qty) ? q_reg : rd_ed.qty;
    assign eq_n     = rd_ed.qty - t_amt;
    assign q_n      = q_reg - t_amt;
    assign tot_n    = tot_reg - TW'(t_amt);
    assign id_ptr   = IW'(id_reg);
    assign cl_new_head = (rd_lh == id_ptr) ? ent_nx_reg : rd_lh;
    assign cl_rescan = (cl_new_head == NIL) &&
                       (ent_side_reg ? (ent_price_reg == best_ask_reg)
                                     : (ent_price_reg == best_bid_reg));
    assign mt_go = (q_reg != '0) &&
                   (sell_reg ? ((p_reg <= best_bid_reg) && (best_bid_reg != '0))
                             : ((p_reg >= best_ask_reg) && (best_ask_reg != TOPP)));
    assign rs_end   = rs_side_reg ? (best_ask_reg == TOPP) : (best_bid_reg == '0);
    assign rs_price = rs_side_reg ? (best_ask_reg + PW'(1)) : (best_bid_reg - PW'(1));
    assign out_load = (state_reg == lobm_pkg::S_OUT) && (!m_valid_reg || m_tready);
    assign s_price_sat = (32'(s_tdata[22:13]) > 32'(TOP_PRICE)) ? TOPP : PW'(s_tdata[22:13]);
    assign s_id_bad    = 32'(s_tdata[11:0]) >= 32'(ORDER_SLOTS);

    assign s_tready = (state_reg == lobm_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lobm_pkg::S_CLEAR: begin
                if (clr_reg == CLR_LAST) state_next = lobm_pkg::S_IDLE;
            end
            lobm_pkg::S_IDLE: begin
                if (s_tvalid) state_next = lobm_pkg::S_CHK;
            end
            lobm_pkg::S_CHK: begin
                state_next = id_bad_reg ? lobm_pkg::S_OUT : lobm_pkg::S_ENT;
            end
            lobm_pkg::S_ENT: begin
                if (kind_reg == lobm_pkg::KIND_CANCEL) begin
                    state_next = rd_ed.live ? lobm_pkg::S_CLEV : lobm_pkg::S_OUT;
                end else if (rd_ed.live || q_reg == '0) begin
                    state_next = lobm_pkg::S_OUT;
                end else begin
                    state_next = lobm_pkg::S_MTOP;
                end
            end
            lobm_pkg::S_CLEV: begin
                state_next = cl_rescan ? lobm_pkg::S_RS_STEP : lobm_pkg::S_OUT;
            end
            lobm_pkg::S_MTOP: begin
                state_next = mt_go ? lobm_pkg::S_MLEV : lobm_pkg::S_REST;
            end
            lobm_pkg::S_MLEV: begin
                state_next = (rd_lh == NIL) ? lobm_pkg::S_RS_STEP : lobm_pkg::S_MORD;
            end
            lobm_pkg::S_MORD: begin
                if (eq_n == '0 && rd_enx == NIL) begin
                    state_next = lobm_pkg::S_RS_STEP;
                end else if (eq_n == '0 && q_n != '0) begin
                    state_next = lobm_pkg::S_MORD;
                end else begin
                    state_next = lobm_pkg::S_MTOP;
                end
            end
            lobm_pkg::S_RS_STEP: begin
                if (!rs_end) begin
                    state_next = lobm_pkg::S_RS_CHK;
                end else if (kind_reg == lobm_pkg::KIND_CANCEL) begin
                    state_next = lobm_pkg::S_OUT;
                end else begin
                    state_next = lobm_pkg::S_MTOP;
                end
            end
            lobm_pkg::S_RS_CHK: begin
                if (rd_lh == NIL) begin
                    state_next = lobm_pkg::S_RS_STEP;
                end else if (kind_reg == lobm_pkg::KIND_CANCEL) begin
                    state_next = lobm_pkg::S_OUT;
                end else begin
                    state_next = lobm_pkg::S_MTOP;
                end
            end
            lobm_pkg::S_REST: begin
                state_next = (q_reg == '0) ? lobm_pkg::S_OUT : lobm_pkg::S_APP;
            end
            lobm_pkg::S_APP: begin
                state_next = (rd_lh != NIL) ? lobm_pkg::S_APP2 : lobm_pkg::S_OUT;
            end
            lobm_pkg::S_APP2: begin
                state_next = lobm_pkg::S_OUT;
            end
            lobm_pkg::S_OUT: begin
                if (out_load) state_next = lobm_pkg::S_IDLE;
            end
            default: begin
                state_next = lobm_pkg::S_CLEAR;
            end
        endcase
    end

    // memory addresses and writes
    always_comb begin
        ea     = id_reg;
        la     = '0;
        lwa    = '0;
        ed_we  = 1'b0;
        ed_wa  = id_reg;
        ed_wd  = '0;
        enx_we = 1'b0;
        enx_wa = id_reg;
        enx_wd = NIL;
        epv_we = 1'b0;
        epv_wa = id_reg;
        epv_wd = NIL;
        lh_we  = 1'b0;
        lh_wd  = NIL;
        lt_we  = 1'b0;
        lt_wd  = NIL;
        lq_we  = 1'b0;
        lq_wd  = '0;
        case (state_reg)
            lobm_pkg::S_CLEAR: begin
                ed_wa = clr_reg[AW-1:0];
                ed_we = 32'(clr_reg) < 32'(ORDER_SLOTS);
                lwa   = clr_reg[LAW-1:0];
                lh_we = 32'(clr_reg) < 32'(LDEPTH);
                lt_we = lh_we;
                lq_we = lh_we;
            end
            lobm_pkg::S_ENT: begin
                la = {rd_ed.price, rd_ed.side};
            end
            lobm_pkg::S_CLEV: begin
                lwa    = {ent_price_reg, ent_side_reg};
                ed_we  = 1'b1;
                epv_we = (ent_nx_reg != NIL);
                epv_wa = ent_nx_reg[AW-1:0];
                epv_wd = ent_pv_reg;
                enx_we = (ent_pv_reg != NIL);
                enx_wa = ent_pv_reg[AW-1:0];
                enx_wd = ent_nx_reg;
                lh_we  = (rd_lh == id_ptr);
                lh_wd  = ent_nx_reg;
                lt_we  = (rd_lt == id_ptr);
                lt_wd  = ent_pv_reg;
                lq_we  = 1'b1;
                lq_wd  = rd_lq - TW'(ent_qty_reg);
            end
            lobm_pkg::S_MTOP: begin
                la = {best_opp, opp};
            end
            lobm_pkg::S_MLEV: begin
                ea = rd_lh[AW-1:0];
            end
            lobm_pkg::S_MORD: begin
                ea    = rd_enx[AW-1:0];
                lwa   = {lvl_reg, opp};
                lq_we = 1'b1;
                lq_wd = tot_n;
                ed_we = 1'b1;
                ed_wa = cur_reg[AW-1:0];
                if (eq_n != '0) begin
                    ed_wd     = rd_ed;
                    ed_wd.qty = eq_n;
                end else begin
                    lh_we = 1'b1;
                    lh_wd = rd_enx;
                    if (rd_enx != NIL) begin
                        epv_we = 1'b1;
                        epv_wa = rd_enx[AW-1:0];
                    end else begin
                        lt_we = 1'b1;
                    end
                end
            end
            lobm_pkg::S_RS_STEP: begin
                la = {rs_price, rs_side_reg};
            end
            lobm_pkg::S_REST: begin
                la = {p_reg, sell_reg};
            end
            lobm_pkg::S_APP: begin
                lwa         = {p_reg, sell_reg};
                ed_we       = 1'b1;
                ed_wd.live  = 1'b1;
                ed_wd.side  = sell_reg;
                ed_wd.price = p_reg;
                ed_wd.qty   = q_reg;
                epv_we      = 1'b1;
                epv_wd      = (rd_lh == NIL) ? NIL : rd_lt;
                enx_we      = 1'b1;
                lh_we       = (rd_lh == NIL);
                lh_wd       = id_ptr;
                lt_we       = 1'b1;
                lt_wd       = id_ptr;
                lq_we       = 1'b1;
                lq_wd       = rd_lq + TW'(q_reg);
            end
            lobm_pkg::S_APP2: begin
                enx_we = 1'b1;
                enx_wa = cur_reg[AW-1:0];
                enx_wd = id_ptr;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lobm_pkg::S_CLEAR;
            clr_reg      <= '0;
            best_bid_reg <= '0;
            best_ask_reg <= TOPP;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == lobm_pkg::S_CLEAR) clr_reg <= clr_reg + CW'(1);
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == lobm_pkg::S_RS_STEP && !rs_end) begin
                if (rs_side_reg) best_ask_reg <= rs_price;
                else             best_bid_reg <= rs_price;
            end
            if (state_reg == lobm_pkg::S_APP) begin
                if (!sell_reg && p_reg > best_bid_reg) best_bid_reg <= p_reg;
                if (sell_reg && p_reg < best_ask_reg)  best_ask_reg <= p_reg;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            lobm_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    kind_reg   <= s_tuser;
                    id_reg     <= AW'(s_tdata[11:0]);
                    id_bad_reg <= s_id_bad;
                    sell_reg   <= s_tdata[12];
                    p_reg      <= s_price_sat;
                    q_reg      <= s_tdata[46:23];
                    filled_reg <= '0;
                    rested_reg <= '0;
                    done_reg   <= '0;
                    status_reg <= lobm_pkg::STAT_OK;
                end
            end
            lobm_pkg::S_CHK: begin
                if (id_bad_reg) begin
                    status_reg <= (kind_reg == lobm_pkg::KIND_CANCEL) ?
                                  lobm_pkg::STAT_NOT_LIVE : lobm_pkg::STAT_DUP;
                end
            end
            lobm_pkg::S_ENT: begin
                ent_side_reg  <= rd_ed.side;
                ent_price_reg <= rd_ed.price;
                ent_qty_reg   <= rd_ed.qty;
                ent_nx_reg    <= rd_enx;
                ent_pv_reg    <= rd_epv;
                if (kind_reg == lobm_pkg::KIND_CANCEL && !rd_ed.live) begin
                    status_reg <= lobm_pkg::STAT_NOT_LIVE;
                end
                if (kind_reg == lobm_pkg::KIND_ADD && rd_ed.live) begin
                    status_reg <= lobm_pkg::STAT_DUP;
                end
            end
            lobm_pkg::S_CLEV: begin
                rs_side_reg <= ent_side_reg;
            end
            lobm_pkg::S_MTOP: begin
                lvl_reg <= best_opp;
            end
            lobm_pkg::S_MLEV: begin
                rs_side_reg <= opp;
                cur_reg     <= rd_lh;
                tot_reg     <= rd_lq;
            end
            lobm_pkg::S_MORD: begin
                q_reg       <= q_n;
                filled_reg  <= filled_reg + t_amt;
                tot_reg     <= tot_n;
                rs_side_reg <= opp;
                if (eq_n == '0) begin
                    cur_reg <= rd_enx;
                    if (done_reg != DONE_MAX) done_reg <= done_reg + DW'(1);
                end
            end
            lobm_pkg::S_APP: begin
                rested_reg <= q_reg;
                cur_reg    <= rd_lt;
            end
            lobm_pkg::S_OUT: begin
                if (out_load) begin
                    m_data_reg <= {5'b0, 10'(best_ask_reg), 10'(best_bid_reg), done_reg,
                                   rested_reg, filled_reg, status_reg};
                end
            end
            default: begin
            end
        endcase
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == lobm_pkg::S_CHK))
        else $error("accepted transaction did not start the sequencer");

    a_sweep_has_qty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lobm_pkg::S_MORD) |-> (q_reg != '0))
        else $error("order sweep entered with no quantity left");

    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lobm_pkg::S_OUT && status_reg != lobm_pkg::STAT_OK) |->
        (filled_reg == '0 && rested_reg == '0 && done_reg == '0))
        else $error("rejected transaction reports trade activity");

    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lobm_pkg::S_CLEAR) |-> !m_valid_reg)
        else $error("result presented during clearing pass");

endmodule

[sim/tb_limit_order_book_matcher_core.sv]
module tb_limit_order_book_matcher_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOPP  = lobm_pkg::TOP_PRICE_DEF;
    localparam int SLOTS = lobm_pkg::ORDER_SLOTS_DEF;
    localparam int NIL   = SLOTS;
    localparam int N_RANDOM = 1030;
    localparam longint LIMIT_CYCLES = 20_000_000;

    typedef struct packed {
        logic [lobm_pkg::STATUS_W-1:0] status;
        logic [lobm_pkg::QTY_W-1:0]    filled;
        logic [lobm_pkg::QTY_W-1:0]    rested;
        logic [lobm_pkg::DONE_W-1:0]   done;
        logic [9:0]                    bid;
        logic [9:0]                    ask;
    } book_result_t;

    class book_scoreboard;
        bit                  live[SLOTS];
        bit                  side[SLOTS];
        int unsigned         price[SLOTS];
        int unsigned         qty[SLOTS];
        int                  prv[SLOTS];
        int                  nxt[SLOTS];
        int                  bid_head[TOPP+1];
        int                  bid_tail[TOPP+1];
        int                  ask_head[TOPP+1];
        int                  ask_tail[TOPP+1];
        int unsigned         best_bid;
        int unsigned         best_ask;
        book_result_t        pending[$];
        int                  errors;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                live[i] = 0;
                prv[i] = NIL;
                nxt[i] = NIL;
            end
            for (int i = 0; i <= TOPP; i++) begin
                bid_head[i] = NIL;
                bid_tail[i] = NIL;
                ask_head[i] = NIL;
                ask_tail[i] = NIL;
            end
            best_bid = 0;
            best_ask = TOPP;
            errors = 0;
        endfunction

        function void link_tail(int id);
            int unsigned p;
            p = price[id];
            prv[id] = NIL;
            nxt[id] = NIL;
            if (side[id]) begin
                if (ask_head[p] == NIL) ask_head[p] = id;
                else begin
                    nxt[ask_tail[p]] = id;
                    prv[id] = ask_tail[p];
                end
                ask_tail[p] = id;
            end else begin
                if (bid_head[p] == NIL) bid_head[p] = id;
                else begin
                    nxt[bid_tail[p]] = id;
                    prv[id] = bid_tail[p];
                end
                bid_tail[p] = id;
            end
        endfunction

        function void unlink(int id);
            int unsigned p;
            p = price[id];
            if (prv[id] != NIL) nxt[prv[id]] = nxt[id];
            if (nxt[id] != NIL) prv[nxt[id]] = prv[id];
            if (side[id]) begin
                if (ask_head[p] == id) ask_head[p] = nxt[id];
                if (ask_tail[p] == id) ask_tail[p] = prv[id];
            end else begin
                if (bid_head[p] == id) bid_head[p] = nxt[id];
                if (bid_tail[p] == id) bid_tail[p] = prv[id];
            end
            prv[id] = NIL;
            nxt[id] = NIL;
        endfunction

        function void rescan_bid();
            while (best_bid > 0 && bid_head[best_bid] == NIL) best_bid--;
        endfunction

        function void rescan_ask();
            while (best_ask < TOPP && ask_head[best_ask] == NIL) best_ask++;
        endfunction

        // trade against the head of the opposite book at its best level
        function void trade_head(bit sell_side, ref int unsigned q,
                                 ref int unsigned filled, ref int unsigned done);
            int cur;
            int unsigned t;
            cur = sell_side ? bid_head[best_bid] : ask_head[best_ask];
            t = (q < qty[cur]) ? q : qty[cur];
            qty[cur] -= t;
            q -= t;
            filled += t;
            if (qty[cur] == 0) begin
                live[cur] = 0;
                unlink(cur);
                if (done < 8191) done++;
            end
        endfunction

        function void note_order(bit kind, int id, bit sell, int unsigned p, int unsigned q);
            book_result_t r;
            int unsigned filled, done, op;
            filled = 0;
            done = 0;
            r = '0;
            if (p > TOPP) p = TOPP;
            if (kind == lobm_pkg::KIND_CANCEL) begin
                if (id >= SLOTS || !live[id]) r.status = lobm_pkg::STAT_NOT_LIVE;
                else begin
                    op = price[id];
                    unlink(id);
                    live[id] = 0;
                    if (!side[id] && bid_head[op] == NIL && op == best_bid) rescan_bid();
                    else if (side[id] && ask_head[op] == NIL && op == best_ask) rescan_ask();
                end
            end else if (id >= SLOTS || live[id]) begin
                r.status = lobm_pkg::STAT_DUP;
            end else begin
                if (!sell) begin
                    while (q > 0 && p >= best_ask && best_ask < TOPP) begin
                        if (ask_head[best_ask] == NIL) rescan_ask();
                        else begin
                            trade_head(1'b0, q, filled, done);
                            if (ask_head[best_ask] == NIL) rescan_ask();
                        end
                    end
                end else begin
                    while (q > 0 && p <= best_bid && best_bid > 0) begin
                        if (bid_head[best_bid] == NIL) rescan_bid();
                        else begin
                            trade_head(1'b1, q, filled, done);
                            if (bid_head[best_bid] == NIL) rescan_bid();
                        end
                    end
                end
                if (q > 0) begin
                    live[id] = 1;
                    side[id] = sell;
                    price[id] = p;
                    qty[id] = q;
                    link_tail(id);
                    r.rested = q;
                    if (!sell && p > best_bid) best_bid = p;
                    if (sell && p < best_ask) best_ask = p;
                end
                r.filled = filled;
                r.done = done;
            end
            r.bid = best_bid;
            r.ask = best_ask;
            pending.push_back(r);
        endfunction

        function void check_result(logic [lobm_pkg::M_DATA_W-1:0] d);
            book_result_t e, a;
            a.status = d[1:0];
            a.filled = d[25:2];
            a.rested = d[49:26];
            a.done   = d[62:50];
            a.bid    = d[72:63];
            a.ask    = d[82:73];
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", d);
                return;
            end
            e = pending.pop_front();
            if (e !== a || d[lobm_pkg::M_DATA_W-1:83] !== '0) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp st=%0d fill=%0d rest=%0d done=%0d bid=%0d ask=%0d",
                        e.status, e.filled, e.rested, e.done, e.bid, e.ask);
                    $display("          act st=%0d fill=%0d rest=%0d done=%0d bid=%0d ask=%0d",
                        a.status, a.filled, a.rested, a.done, a.bid, a.ask);
                end
            end
        endfunction
    endclass

    logic                          aclk = 0;
    logic                          aresetn = 0;
    logic                          s_tvalid = 0;
    logic                          s_tready;
    logic [lobm_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                          s_tuser = 0;
    logic                          m_tvalid;
    logic                          m_tready = 0;
    logic [lobm_pkg::M_DATA_W-1:0] m_tdata;

    book_scoreboard book = new();
    longint cycles = 0;
    bit     no_idle = 0;
    int     used_ids[$];

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    limit_order_book_matcher_core u_top (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) book.check_result(m_tdata);
    end

    initial begin
        int w;
        @(posedge aclk);
        forever begin
            w = no_idle ? 0 : $urandom_range(0, 11);
            m_tready <= (w == 0);
            repeat (w) @(posedge aclk);
            m_tready <= 1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    task automatic send_order(bit kind, int id, bit sell, int unsigned p, int unsigned q);
        int w;
        w = no_idle ? 0 : $urandom_range(0, 11);
        if (w > 0) begin
            s_tvalid <= 0;
            repeat (w) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, q[23:0], p[9:0], sell, id[11:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        book.note_order(kind, id, sell, p, q);
    endtask

    function automatic int pick_id();
        if (used_ids.size() > 0 && $urandom_range(0, 2) == 0)
            return used_ids[$urandom_range(0, used_ids.size() - 1)];
        pick_id = $urandom_range(0, 4095);
        used_ids.push_back(pick_id);
        if (used_ids.size() > 200) void'(used_ids.pop_front());
    endfunction

    initial begin
        int unsigned p, q, id;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_order(lobm_pkg::KIND_ADD, 0, 0, 0, 100);
        send_order(lobm_pkg::KIND_ADD, 4095, 1, 1023, 50);
        send_order(lobm_pkg::KIND_ADD, 1, 1, 0, 30);
        send_order(lobm_pkg::KIND_ADD, 2, 0, 1023, 10);
        send_order(lobm_pkg::KIND_ADD, 3, 0, 500, 24'hFFFFFF);
        send_order(lobm_pkg::KIND_ADD, 3, 1, 500, 5);
        send_order(lobm_pkg::KIND_ADD, 4, 1, 400, 0);
        send_order(lobm_pkg::KIND_ADD, 5, 1, 510, 7);
        send_order(lobm_pkg::KIND_ADD, 6, 1, 510, 9);
        send_order(lobm_pkg::KIND_ADD, 7, 0, 520, 12);
        send_order(lobm_pkg::KIND_ADD, 8, 1, 1, 24'hFFFFFF);
        send_order(lobm_pkg::KIND_CANCEL, 9, 0, 0, 0);
        send_order(lobm_pkg::KIND_CANCEL, 6, 1, 1023, 24'hFFFFFF);
        send_order(lobm_pkg::KIND_CANCEL, 8, 0, 0, 0);
        send_order(lobm_pkg::KIND_CANCEL, 8, 0, 0, 0);
        send_order(lobm_pkg::KIND_ADD, 10, 0, 300, 5);
        send_order(lobm_pkg::KIND_ADD, 11, 0, 200, 5);
        send_order(lobm_pkg::KIND_CANCEL, 10, 0, 0, 0);
        send_order(lobm_pkg::KIND_ADD, 12, 1, 100, 24'hFFFFFF);
        send_order(lobm_pkg::KIND_CANCEL, 4095, 0, 0, 0);
        send_order(lobm_pkg::KIND_CANCEL, 0, 0, 0, 0);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
            id = pick_id();
            case ($urandom_range(0, 9))
                0: p = $urandom_range(0, 1023);
                default: p = $urandom_range(480, 544);
            endcase
            case ($urandom_range(0, 9))
                0: q = $urandom();
                1: q = 0;
                default: q = $urandom_range(1, 300);
            endcase
            if ($urandom_range(0, 3) == 0)
                send_order(lobm_pkg::KIND_CANCEL, id, $urandom_range(0, 1),
                           $urandom_range(0, 1023), $urandom());
            else
                send_order(lobm_pkg::KIND_ADD, id, $urandom_range(0, 1), p, q[23:0]);
        end
        s_tvalid <= 0;
        no_idle = 0;
        while (book.pending.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (book.errors == 0 && book.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
